// ----- src/alln_pkg.sv -----
// ============================================================================
// alln_pkg : shared types and constants of the light level normaliser
// Widths, reset values, register indexes and the sequencer state type.
// ============================================================================
`default_nettype none

package alln_pkg;

    // Bound format: unsigned Q(SAMPLE_BITS).(FRAC_BITS)
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int BOUND_W     = SAMPLE_BITS + FRAC_BITS;

    // Port field widths
    localparam int FIELD_W     = 16;
    localparam int LIMIT_W     = 16;
    localparam int DECAY_W     = 16;
    localparam int FACTOR_W    = 17;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 16;

    // Factor products are taken back down by this many bits
    localparam int SCALE_SHIFT = 16;

    // Result is Q4.12; the guard bits are the integer part
    localparam int OUT_FRAC    = 12;
    localparam int GUARD_W     = FIELD_W - OUT_FRAC;

    typedef logic [BOUND_W-1:0]  bound_t;
    typedef logic [FACTOR_W-1:0] factor_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam bound_t BOUND_TOP = '1;
    localparam bound_t ONE_UNIT  = bound_t'(1) << FRAC_BITS;
    localparam bound_t MIN_RESET = bound_t'(500) << FRAC_BITS;
    localparam bound_t MAX_RESET = bound_t'(800) << FRAC_BITS;

    localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = LIMIT_W'(999);
    localparam logic [DECAY_W-1:0] DECAY_RESET      = DECAY_W'(64880);
    localparam factor_t            RISE_RESET       = FACTOR_W'(66191);
    localparam factor_t            SPAN_RESET       = FACTOR_W'(91750);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_LIMIT,
        CFG_DECAY,
        CFG_RISE,
        CFG_SPAN
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DECAY,
        ST_RISE,
        ST_SPAN,
        ST_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- src/alln_mul.sv -----
// ============================================================================
// alln_mul : bit-serial bound scaler
// Shift-add multiply of a bound by a Q1.16 factor, one factor bit a cycle,
// result shifted down and saturated to the bound range.
// ============================================================================
`default_nettype none

module alln_mul (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire alln_pkg::bound_t bound,
    input  wire alln_pkg::factor_t factor,
    output logic                  done,
    output alln_pkg::bound_t      product
);

    localparam int PROD_W   = alln_pkg::BOUND_W + alln_pkg::FACTOR_W;
    localparam int SCALED_W = PROD_W - alln_pkg::SCALE_SHIFT;
    localparam int STEP_W   = $clog2(alln_pkg::FACTOR_W);

    logic [PROD_W-1:0]      acc_reg, acc_next;
    alln_pkg::bound_t       mcand_reg, mcand_next;
    alln_pkg::factor_t      mplier_reg, mplier_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [alln_pkg::BOUND_W:0] partial;
    logic [SCALED_W-1:0]        scaled;

    always_comb
    begin
        partial = {1'b0, acc_reg[PROD_W-1:alln_pkg::FACTOR_W]}
                + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);

        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = busy_reg && (step_reg == '0);

        if (start)
        begin
            acc_next    = '0;
            mcand_next  = bound;
            mplier_next = factor;
            step_next   = STEP_W'(alln_pkg::FACTOR_W - 1);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next    = {partial, acc_reg[alln_pkg::FACTOR_W-1:1]};
            mplier_next = mplier_reg >> 1;
            step_next   = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // Truncating shift, then clamp to the largest bound
    always_comb
    begin
        scaled = acc_reg[PROD_W-1:alln_pkg::SCALE_SHIFT];
        if (scaled > SCALED_W'(alln_pkg::BOUND_TOP))
        begin
            product = alln_pkg::BOUND_TOP;
        end
        else
        begin
            product = scaled[alln_pkg::BOUND_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- src/alln_div.sv -----
// ============================================================================
// alln_div : bit-serial fraction divider
// Restoring division (num << 12) / den, one quotient bit a cycle, with the
// quotient saturated at all ones when it would not fit 16 bits.
// ============================================================================
`default_nettype none

module alln_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire alln_pkg::bound_t num,
    input  wire alln_pkg::bound_t den,
    output logic                  done,
    output logic [alln_pkg::FIELD_W-1:0] quot
);

    localparam int STEP_W = $clog2(alln_pkg::FIELD_W);
    localparam int CMP_W  = alln_pkg::BOUND_W + alln_pkg::GUARD_W;

    alln_pkg::bound_t              rem_reg, rem_next;
    alln_pkg::bound_t              den_reg, den_next;
    logic [alln_pkg::FIELD_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic                          sat;
    logic [alln_pkg::BOUND_W:0]    trial;
    logic [alln_pkg::BOUND_W:0]    diff;
    logic                          fits;

    always_comb
    begin
        // Quotient overflows 16 bits exactly when num >= den * 16
        sat   = CMP_W'(num) >= {den, {alln_pkg::GUARD_W{1'b0}}};
        trial = {rem_reg, quot_reg[alln_pkg::FIELD_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};

        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (step_reg == '0);

        if (start)
        begin
            den_next = den;
            if (sat)
            begin
                quot_next = '1;
                done_next = 1'b1;
            end
            else
            begin
                // Upper dividend bits seed the remainder, low nibble rides in quot
                rem_next  = num >> alln_pkg::GUARD_W;
                quot_next = {num[alln_pkg::GUARD_W-1:0], {alln_pkg::OUT_FRAC{1'b0}}};
                step_next = STEP_W'(alln_pkg::FIELD_W - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[alln_pkg::BOUND_W-1:0] : trial[alln_pkg::BOUND_W-1:0];
            quot_next = {quot_reg[alln_pkg::FIELD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- src/adaptive_light_level_normalizer_core.sv -----
// ============================================================================
// adaptive_light_level_normalizer_core : adaptive min/max light normaliser
// Tracks running light bounds and gives each sample's place between them.
// ============================================================================
// Sequence: each input beat passes ST_UPDATE, a span job on the bit-serial
//   17-step scaler, ST_CMP, the divider and ST_OUT; each bound relaxation adds
//   a scaler job. A saturated fraction cuts the divider short, an empty span skips it.
// Throughput: one beat at a time; a new beat is taken once the result has
//   moved to the output register, while that result waits for out_ready.
// Reset: rst_n asynchronous, active low; bounds 500.0 / 800.0, idle counts 0,
//   registers to their defaults, no output beat pending.
// ============================================================================
`default_nettype none

module adaptive_light_level_normalizer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [alln_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [alln_pkg::CFG_W-1:0]        cfg_data,

    // sample channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [alln_pkg::FIELD_W-1:0]      clear_level,

    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [alln_pkg::FIELD_W-1:0]           light_fraction,
    output logic [alln_pkg::FIELD_W-1:0]           level_low,
    output logic [alln_pkg::FIELD_W-1:0]           level_high,
    output logic                                   span_zero
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [alln_pkg::LIMIT_W-1:0] idle_limit_reg;
    logic [alln_pkg::DECAY_W-1:0] decay_reg;
    alln_pkg::factor_t            rise_reg;
    alln_pkg::factor_t            span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= alln_pkg::IDLE_LIMIT_RESET;
            decay_reg      <= alln_pkg::DECAY_RESET;
            rise_reg       <= alln_pkg::RISE_RESET;
            span_reg       <= alln_pkg::SPAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (alln_pkg::cfg_idx_t'(cfg_index))
                alln_pkg::CFG_IDLE_LIMIT: idle_limit_reg <= alln_pkg::LIMIT_W'(cfg_data);
                alln_pkg::CFG_DECAY:      decay_reg      <= alln_pkg::DECAY_W'(cfg_data);
                alln_pkg::CFG_RISE:       rise_reg       <= cfg_data;
                alln_pkg::CFG_SPAN:       span_reg       <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    alln_pkg::state_t             state_reg, state_next;
    alln_pkg::bound_t             sample_reg, sample_next;
    alln_pkg::bound_t             min_reg, min_next;
    alln_pkg::bound_t             max_reg, max_next;
    alln_pkg::count_t             min_cnt_reg, min_cnt_next;
    alln_pkg::count_t             max_cnt_reg, max_cnt_next;
    logic                         rise_pend_reg, rise_pend_next;
    logic [alln_pkg::FIELD_W-1:0] frac_reg, frac_next;
    logic                         zero_reg, zero_next;

    logic                         out_valid_reg, out_valid_next;
    logic [alln_pkg::FIELD_W-1:0] fraction_reg, fraction_next;
    logic [alln_pkg::FIELD_W-1:0] low_reg, low_next;
    logic [alln_pkg::FIELD_W-1:0] high_reg, high_next;
    logic                         span_zero_reg, span_zero_next;

    // ------------------------------------------------------------------
    // Serial scaler and divider
    // ------------------------------------------------------------------
    logic                         mul_start;
    alln_pkg::bound_t             mul_bound;
    alln_pkg::factor_t            mul_factor;
    logic                         mul_done;
    alln_pkg::bound_t             mul_product;

    logic                         div_start;
    alln_pkg::bound_t             div_num;
    alln_pkg::bound_t             div_den;
    logic                         div_done;
    logic [alln_pkg::FIELD_W-1:0] div_quot;

    alln_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .bound   (mul_bound),
        .factor  (mul_factor),
        .done    (mul_done),
        .product (mul_product)
    );

    alln_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Bound update terms, read in ST_UPDATE
    // ------------------------------------------------------------------
    logic [alln_pkg::BOUND_W:0]   climb_sum;
    alln_pkg::bound_t             max_climb;
    alln_pkg::bound_t             max_upd;
    alln_pkg::bound_t             min_upd;
    alln_pkg::count_t             max_cnt_bump;
    alln_pkg::count_t             min_cnt_bump;
    logic                         max_up;
    logic                         min_down;
    logic                         decay_c;
    logic                         rise_c;
    logic [alln_pkg::SAMPLE_BITS-1:0] sample_int;

    always_comb
    begin
        sample_int   = alln_pkg::SAMPLE_BITS'(clear_level);

        climb_sum    = {1'b0, max_reg} + {1'b0, alln_pkg::ONE_UNIT};
        max_climb    = climb_sum[alln_pkg::BOUND_W] ? alln_pkg::BOUND_TOP
                                                    : climb_sum[alln_pkg::BOUND_W-1:0];
        // idle counters stick at all ones
        max_cnt_bump = (max_cnt_reg == '1) ? max_cnt_reg : max_cnt_reg + 1'b1;
        min_cnt_bump = (min_cnt_reg == '1) ? min_cnt_reg : min_cnt_reg + 1'b1;

        max_up       = max_reg < sample_reg;
        min_down     = min_reg > sample_reg;
        decay_c      = !max_up   && (max_cnt_bump > idle_limit_reg);
        rise_c       = !min_down && (min_cnt_bump > idle_limit_reg);

        max_upd      = max_up   ? max_climb  : max_reg;
        min_upd      = min_down ? sample_reg : min_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            alln_pkg::ST_IDLE:
                if (in_valid) state_next = alln_pkg::ST_UPDATE;
            alln_pkg::ST_UPDATE:
                if (decay_c)     state_next = alln_pkg::ST_DECAY;
                else if (rise_c) state_next = alln_pkg::ST_RISE;
                else             state_next = alln_pkg::ST_SPAN;
            alln_pkg::ST_DECAY:
                if (mul_done) state_next = rise_pend_reg ? alln_pkg::ST_RISE
                                                         : alln_pkg::ST_SPAN;
            alln_pkg::ST_RISE:
                if (mul_done) state_next = alln_pkg::ST_SPAN;
            alln_pkg::ST_SPAN:
                if (mul_done) state_next = alln_pkg::ST_CMP;
            alln_pkg::ST_CMP:
                state_next = (max_reg <= min_reg) ? alln_pkg::ST_OUT : alln_pkg::ST_DIV;
            alln_pkg::ST_DIV:
                if (div_done) state_next = alln_pkg::ST_OUT;
            alln_pkg::ST_OUT:
                if (!out_valid_reg || out_ready) state_next = alln_pkg::ST_IDLE;
            default:
                state_next = alln_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and unit control
    // ------------------------------------------------------------------
    always_comb
    begin
        sample_next    = sample_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        min_cnt_next   = min_cnt_reg;
        max_cnt_next   = max_cnt_reg;
        rise_pend_next = rise_pend_reg;
        frac_next      = frac_reg;
        zero_next      = zero_reg;

        out_valid_next = out_valid_reg && !out_ready;
        fraction_next  = fraction_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        span_zero_next = span_zero_reg;

        mul_start      = 1'b0;
        mul_bound      = min_reg;
        mul_factor     = span_reg;
        div_start      = 1'b0;
        div_num        = (sample_reg > min_reg) ? sample_reg - min_reg : '0;
        div_den        = max_reg - min_reg;

        unique case (state_reg)
            alln_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = {sample_int, {alln_pkg::FRAC_BITS{1'b0}}};
                end
            end

            alln_pkg::ST_UPDATE:
            begin
                max_next       = max_upd;
                min_next       = min_upd;
                max_cnt_next   = (max_up || decay_c) ? '0 : max_cnt_bump;
                min_cnt_next   = (min_down || rise_c) ? '0 : min_cnt_bump;
                rise_pend_next = rise_c;
                // first scaler job: decay, else rise, else the span floor
                mul_start      = 1'b1;
                if (decay_c)
                begin
                    mul_bound  = max_upd;
                    mul_factor = alln_pkg::FACTOR_W'(decay_reg);
                end
                else if (rise_c)
                begin
                    mul_bound  = min_upd;
                    mul_factor = rise_reg;
                end
                else
                begin
                    mul_bound  = min_upd;
                    mul_factor = span_reg;
                end
            end

            alln_pkg::ST_DECAY:
            begin
                mul_bound  = min_reg;
                mul_factor = rise_pend_reg ? rise_reg : span_reg;
                if (mul_done)
                begin
                    max_next  = mul_product;
                    mul_start = 1'b1;
                end
            end

            alln_pkg::ST_RISE:
            begin
                mul_bound  = mul_product;
                mul_factor = span_reg;
                if (mul_done)
                begin
                    min_next  = mul_product;
                    mul_start = 1'b1;
                end
            end

            alln_pkg::ST_SPAN:
            begin
                // keep the maximum at least span_ratio times the minimum
                if (mul_done && (max_reg < mul_product))
                begin
                    max_next = mul_product;
                end
            end

            alln_pkg::ST_CMP:
            begin
                if (max_reg <= min_reg)
                begin
                    zero_next = 1'b1;
                    frac_next = '0;
                end
                else
                begin
                    zero_next = 1'b0;
                    div_start = 1'b1;
                end
            end

            alln_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    frac_next = div_quot;
                end
            end

            alln_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    fraction_next  = frac_reg;
                    low_next       = alln_pkg::FIELD_W'(min_reg[alln_pkg::BOUND_W-1:
                                                                alln_pkg::FRAC_BITS]);
                    high_next      = alln_pkg::FIELD_W'(max_reg[alln_pkg::BOUND_W-1:
                                                                alln_pkg::FRAC_BITS]);
                    span_zero_next = zero_reg;
                end
            end

            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alln_pkg::ST_IDLE;
            min_reg       <= alln_pkg::MIN_RESET;
            max_reg       <= alln_pkg::MAX_RESET;
            min_cnt_reg   <= '0;
            max_cnt_reg   <= '0;
            rise_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            min_cnt_reg   <= min_cnt_next;
            max_cnt_reg   <= max_cnt_next;
            rise_pend_reg <= rise_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        frac_reg      <= frac_next;
        zero_reg      <= zero_next;
        fraction_reg  <= fraction_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        span_zero_reg <= span_zero_next;
    end

    assign in_ready       = (state_reg == alln_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign light_fraction = fraction_reg;
    assign level_low      = low_reg;
    assign level_high     = high_reg;
    assign span_zero      = span_zero_reg;

endmodule

`default_nettype wire

// ----- sim/alln_norm_checker.sv -----
// ============================================================================
// alln_norm_checker : result checker for the light level normaliser
// Mirrors the register file and the bound tracking, predicts every result
// beat from the sample beats it sees and compares field by field.
// ============================================================================

module alln_norm_checker
    import alln_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [FIELD_W-1:0]    clear_level,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [FIELD_W-1:0]    light_fraction,
    input  wire logic [FIELD_W-1:0]    level_low,
    input  wire logic [FIELD_W-1:0]    level_high,
    input  wire logic                  span_zero,
    output int                         mismatches,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FIELD_W-1:0] fraction;
        logic [FIELD_W-1:0] low;
        logic [FIELD_W-1:0] high;
        logic               empty;
    } level_beat_t;

    // register mirror
    logic [LIMIT_W-1:0] idle_limit_q;
    logic [DECAY_W-1:0] decay_q;
    factor_t            rise_q;
    factor_t            span_q;

    // tracked bounds, Q16.8
    bound_t             min_b;
    bound_t             max_b;
    count_t             min_idle;
    count_t             max_idle;

    level_beat_t        expected_levels[$];
    level_beat_t        want;
    level_beat_t        fresh;

    function automatic bound_t scale_bound(bound_t b, factor_t f);
        logic [63:0] p;
        p = (64'(b) * 64'(f)) >> SCALE_SHIFT;
        return (p > 64'(BOUND_TOP)) ? BOUND_TOP : bound_t'(p);
    endfunction

    function automatic count_t bump_idle(count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    task automatic normalise_sample(input logic [FIELD_W-1:0] level, output level_beat_t r);
        bound_t         s;
        bound_t         floor_b;
        logic [BOUND_W:0] climbed;
        logic [63:0]    num;
        logic [63:0]    den;
        logic [63:0]    q;

        s = bound_t'(level) << FRAC_BITS;

        // maximum: climb one unit, or decay after too long idle
        if (max_b < s) begin
            climbed  = {1'b0, max_b} + ONE_UNIT;
            max_b    = climbed[BOUND_W] ? BOUND_TOP : climbed[BOUND_W-1:0];
            max_idle = '0;
        end else begin
            max_idle = bump_idle(max_idle);
            if (max_idle > idle_limit_q) begin
                max_b    = scale_bound(max_b, factor_t'(decay_q));
                max_idle = '0;
            end
        end

        // minimum: snap down, or rise after too long idle
        if (min_b > s) begin
            min_b    = s;
            min_idle = '0;
        end else begin
            min_idle = bump_idle(min_idle);
            if (min_idle > idle_limit_q) begin
                min_b    = scale_bound(min_b, rise_q);
                min_idle = '0;
            end
        end

        floor_b = scale_bound(min_b, span_q);
        if (max_b < floor_b)
            max_b = floor_b;

        r.empty    = 1'b0;
        r.fraction = '0;
        if (max_b <= min_b) begin
            r.empty = 1'b1;
        end else begin
            den = 64'(max_b - min_b);
            num = (s > min_b) ? 64'(s - min_b) : 64'd0;
            q   = (num << OUT_FRAC) / den;
            r.fraction = (q > 64'hFFFF) ? 16'hFFFF : q[FIELD_W-1:0];
        end
        r.low  = FIELD_W'(min_b >> FRAC_BITS);
        r.high = FIELD_W'(max_b >> FRAC_BITS);
    endtask

    task automatic note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
        $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idle_limit_q = IDLE_LIMIT_RESET;
            decay_q      = DECAY_RESET;
            rise_q       = RISE_RESET;
            span_q       = SPAN_RESET;
            min_b        = MIN_RESET;
            max_b        = MAX_RESET;
            min_idle     = '0;
            max_idle     = '0;
            expected_levels.delete();
            outstanding  <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_IDLE_LIMIT: idle_limit_q = cfg_data[LIMIT_W-1:0];
                    CFG_DECAY:      decay_q      = cfg_data[DECAY_W-1:0];
                    CFG_RISE:       rise_q       = cfg_data[FACTOR_W-1:0];
                    CFG_SPAN:       span_q       = cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end

            // result side first, so a beat never matches its own sample
            if (out_valid && out_ready) begin
                if (expected_levels.size() == 0) begin
                    note_mismatch("unexpected result beat, pending", 0, 1);
                end else begin
                    want = expected_levels.pop_front();
                    if (light_fraction !== want.fraction)
                        note_mismatch("light_fraction", want.fraction, light_fraction);
                    if (level_low !== want.low)
                        note_mismatch("level_low", want.low, level_low);
                    if (level_high !== want.high)
                        note_mismatch("level_high", want.high, level_high);
                    if (span_zero !== want.empty)
                        note_mismatch("span_zero", want.empty, span_zero);
                end
            end

            if (in_valid && in_ready) begin
                normalise_sample(clear_level, fresh);
                expected_levels.push_back(fresh);
            end

            outstanding <= expected_levels.size();
        end
    end

endmodule

// ----- sim/adaptive_light_level_normalizer_core_tb.sv -----
// ============================================================================
// adaptive_light_level_normalizer_core_tb : testbench top of the normaliser
// Drives sample beats and register writes with random idling on both
// channels; the checker beside the block predicts and compares each result.
// ============================================================================

module adaptive_light_level_normalizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alln_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    // slowest beat is its work plus the longest sender gap and stall; over some
    // 450 beats of that, this leaves a wide margin
    localparam int CYCLE_LIMIT   = 800000;
    // a little over the longest latency, for the tail of the run
    localparam int SETTLE_CYCLES = 100;
    localparam int IDLE_SETTLE   = 4;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [FIELD_W-1:0]    clear_level = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [FIELD_W-1:0]    light_fraction;
    logic [FIELD_W-1:0]    level_low;
    logic [FIELD_W-1:0]    level_high;
    logic                  span_zero;

    int                    mismatches;
    int                    outstanding;
    int                    cycles = 0;

    // when set, neither side idles
    bit                    steady = 1'b0;
    // slowly wandering light level for the sensor-like part of the stimulus
    logic [FIELD_W-1:0]    drift  = 16'd600;

    always #(CLK_HALF) clk = ~clk;

    adaptive_light_level_normalizer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .clear_level    (clear_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .light_fraction (light_fraction),
        .level_low      (level_low),
        .level_high     (level_high),
        .span_zero      (span_zero)
    );

    alln_norm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .clear_level    (clear_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .light_fraction (light_fraction),
        .level_low      (level_low),
        .level_high     (level_high),
        .span_zero      (span_zero),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle length in cycles: mostly none or short, now and then a long one
    function automatic int draw_gap();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // Sample mix: a drifting sensor level, uniform noise, the rails, and
    // dim readings near the bottom of the range
    function automatic logic [FIELD_W-1:0] next_sample();
        int pick;
        int level;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            drift = FIELD_W'($urandom_range(0, 65535));
            return drift;
        end else if (pick < 43) begin
            level = int'(drift) + int'($urandom_range(0, 64)) - 32;
            if (level < 0)
                level = 0;
            if (level > 65535)
                level = 65535;
            drift = level[FIELD_W-1:0];
            return drift;
        end else if (pick < 60) begin
            return FIELD_W'($urandom_range(0, 65535));
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0:       return 16'd0;
                1:       return 16'hFFFF;
                2:       return 16'd1;
                default: return 16'hFFFE;
            endcase
        end else begin
            return FIELD_W'($urandom_range(0, 1023));
        end
    endfunction

    // One sample beat. Valid stays up across a zero gap so that back-to-back
    // beats never see valid lowered and raised in one step.
    task automatic send_sample(input logic [FIELD_W-1:0] level);
        int gap;
        in_valid    <= 1'b1;
        clear_level <= level;
        do
            @(posedge clk);
        while (!in_ready);
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering beats and wait for every predicted result to arrive.
    // One result per beat, so the block is idle once the store is empty.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic load_regs(input logic [LIMIT_W-1:0] limit, input logic [DECAY_W-1:0] decay,
                             input factor_t rise, input factor_t span);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDLE_LIMIT;
        cfg_data  <= CFG_W'(limit);
        @(posedge clk);
        cfg_index <= CFG_DECAY;
        cfg_data  <= CFG_W'(decay);
        @(posedge clk);
        cfg_index <= CFG_RISE;
        cfg_data  <= rise;
        @(posedge clk);
        cfg_index <= CFG_SPAN;
        cfg_data  <= span;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random beats under one register setting; pause_at < 0 means no pause
    task automatic run_phase(input int beats, input int pause_at);
        for (int i = 0; i < beats; i++) begin
            // sender holds off until the block has fully emptied
            if (i == pause_at)
                drain_results();
            send_sample(next_sample());
        end
        drain_results();
    endtask

    // Result side: random stalls of the same shape as the sender's gaps
    initial begin
        int hold;
        int run;
        wait (rst_n);
        @(posedge clk);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    initial begin
        logic [FIELD_W-1:0] corners[11];
        corners = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd800, 16'd500, 16'd1,
                    16'hFFFE, 16'h8000, 16'h5555, 16'hAAAA, 16'd100};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: rails, the reset bounds, alternating bits
        foreach (corners[i])
            send_sample(corners[i]);
        drain_results();

        // Directed, harshest setting: every idle beat relaxes, the minimum
        // doubles each time and the span rule drags the maximum with it, so
        // both bounds hit the top and the span empties; samples below a
        // risen minimum clamp the fraction to zero
        load_regs(16'd0, 16'd0, factor_t'(131071), factor_t'(131071));
        repeat (12) send_sample(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'd30000);
        drain_results();

        // Random: short idle limits, factors in their usual range; includes
        // the full pause of the sender
        load_regs(LIMIT_W'($urandom_range(0, 3)), DECAY_W'($urandom_range(60000, 65535)),
                  factor_t'($urandom_range(65536, 70000)),
                  factor_t'($urandom_range(65536, 131071)));
        run_phase(75, 40);

        // Random at the extreme setting, with no idling on either side
        steady = 1'b1;
        load_regs(16'd0, 16'd0, factor_t'(131071), factor_t'(131071));
        run_phase(60, -1);
        steady = 1'b0;

        // Other extreme: bounds never relax, rise and span factors at exactly one
        load_regs(16'hFFFF, 16'hFFFF, factor_t'(65536), factor_t'(65536));
        run_phase(60, -1);

        // Span ratio below one, rise factor anywhere: inverted spans
        load_regs(LIMIT_W'($urandom_range(0, 8)), DECAY_W'($urandom_range(0, 65535)),
                  factor_t'($urandom_range(0, 131071)), factor_t'($urandom_range(0, 65535)));
        run_phase(75, -1);

        // Fully random factors in range, moderate idle limit
        load_regs(LIMIT_W'($urandom_range(0, 20)), DECAY_W'($urandom_range(0, 65535)),
                  factor_t'($urandom_range(65536, 131071)),
                  factor_t'($urandom_range(65536, 131071)));
        run_phase(75, -1);

        // Back to the reset values with a medium idle limit
        load_regs(LIMIT_W'($urandom_range(30, 200)), DECAY_RESET, RISE_RESET, SPAN_RESET);
        run_phase(75, -1);

        // Tail: anything still coming out now is a spurious beat
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
